@@ hdl/assert_macros.svh @@
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, off during reset
`define AST_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// clocked implication checked in the cycle after the antecedent
`define AST_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/pfc_pkg.sv @@
// types, widths and codes of the point frustum cull block
package pfc_pkg;
  localparam int IDX_W       = 24;
  localparam int COORD_W     = 32;
  localparam int FOC_W       = 24;
  localparam int SIZE_W      = 16;
  localparam int DEPTH_W     = 31;
  localparam int PROD_W      = 56;
  localparam int SPROD_W     = 47;
  localparam int QUO_W       = 24;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 31;
  localparam int POINT_INDEX_BITS_DEF = 24;

  localparam logic [STATUS_W-1:0] ST_KEPT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEPTH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOV   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IMAGE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FAR   = 3'd6;

  typedef struct packed {
    logic [FOC_W-1:0]   focal;
    logic [FOC_W-1:0]   px;
    logic [FOC_W-1:0]   py;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [DEPTH_W-1:0] near;
    logic [DEPTH_W-1:0] far;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               depth_fail;
    logic               xneg;
    logic               yneg;
    logic [DEPTH_W-1:0] z;
    logic [PROD_W-1:0]  fx;
    logic [PROD_W-1:0]  fy;
    logic [SPROD_W-1:0] zw;
    logic [SPROD_W-1:0] zh;
  } front_t;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [STATUS_W-1:0] status;
    logic                xneg;
    logic                yneg;
    logic [DEPTH_W-1:0]  z;
    logic [PROD_W-1:0]   ru;
    logic [PROD_W-1:0]   rv;
    logic [QUO_W-1:0]    qu;
    logic [QUO_W-1:0]    qv;
  } div_t;
endpackage

@@ hdl/point_frustum_cull_project.sv @@
// top level of the point frustum cull and projection block
// Streams camera-frame points (signed Q16.16) and returns one result item per
// point: the index, the projected column and row in 1/256 pixel, and a status
// (0 kept, 1 depth outside [near, far], 2 outside the field of view, 3 lands
// off the image). One item is accepted every cycle unless the output stalls;
// items pass the cells in order (front multiply cell, field of view cell, 24
// restoring divider cells that each settle one quotient bit of u and v, output
// cell). Every cell has its own valid bit and takes a new item whenever it is
// empty or its neighbor takes its item, so bubbles close up and input keeps
// flowing while a finished result waits at the output. Configuration registers
// are written through cfg_write/cfg_index/cfg_data and must only change while no
// item is in flight; indexes beyond the register list are ignored.
module point_frustum_cull_project #(
  parameter int POINT_INDEX_BITS = pfc_pkg::POINT_INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pfc_pkg::COORD_W-1:0]       pos_x,
  input  logic [pfc_pkg::COORD_W-1:0]       pos_y,
  input  logic [pfc_pkg::COORD_W-1:0]       pos_z,
  input  logic [pfc_pkg::IDX_W-1:0]         point_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pfc_pkg::IDX_W-1:0]         point_index_out,
  output logic [pfc_pkg::FOC_W-1:0]         pixel_u,
  output logic [pfc_pkg::FOC_W-1:0]         pixel_v,
  output logic [pfc_pkg::STATUS_W-1:0]      status
);
  import pfc_pkg::*;
  `include "assert_macros.svh"

  // index bits kept: the lower of the parameter and the port width
  localparam int KEEP_BITS = (POINT_INDEX_BITS < IDX_W) ? POINT_INDEX_BITS : IDX_W;
  localparam logic [IDX_W-1:0] IDX_MASK = {IDX_W{1'b1}} >> (IDX_W - KEEP_BITS);

  cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal <= FOC_W'(256000);
      cfg.px    <= FOC_W'(245760);
      cfg.py    <= FOC_W'(138240);
      cfg.w     <= SIZE_W'(1920);
      cfg.h     <= SIZE_W'(1080);
      cfg.near  <= DEPTH_W'(65536);
      cfg.far   <= DEPTH_W'(26214400);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FOCAL: cfg.focal <= cfg_data[FOC_W-1:0];
        REG_PX:    cfg.px    <= cfg_data[FOC_W-1:0];
        REG_PY:    cfg.py    <= cfg_data[FOC_W-1:0];
        REG_W:     cfg.w     <= cfg_data[SIZE_W-1:0];
        REG_H:     cfg.h     <= cfg_data[SIZE_W-1:0];
        REG_NEAR:  cfg.near  <= cfg_data[DEPTH_W-1:0];
        REG_FAR:   cfg.far   <= cfg_data[DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front cell
  logic   f_valid, f_ready;
  front_t f_item;

  pfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .idx      (point_index & IDX_MASK),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_item  (f_item)
  );

  // chain of divider cells, most significant quotient bit first
  logic [QUO_W:0] c_valid, c_ready;
  div_t           c_item [QUO_W+1];

  pfc_screen u_screen (
    .clk      (clk),
    .rst      (rst),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_item  (f_item),
    .dn_valid (c_valid[0]),
    .dn_ready (c_ready[0]),
    .dn_item  (c_item[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    pfc_div_cell #(.BIT(QUO_W - 1 - i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .up_item  (c_item[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .dn_item  (c_item[i+1])
    );
  end

  // output cell
  pfc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .up_valid        (c_valid[QUO_W]),
    .up_ready        (c_ready[QUO_W]),
    .up_item         (c_item[QUO_W]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .point_index_out (point_index_out),
    .pixel_u         (pixel_u),
    .pixel_v         (pixel_v),
    .status          (status)
  );

  // rejected items carry no pixel position
  `AST_IMPLY(a_reject_zero, clk, rst, out_valid && status != ST_KEPT, pixel_u == '0 && pixel_v == '0)
  // kept items land on the image
  `AST_IMPLY(a_kept_u, clk, rst, out_valid && status == ST_KEPT, {8'b0, pixel_u} < {cfg.w, 16'b0} >> 8)
  `AST_IMPLY(a_kept_v, clk, rst, out_valid && status == ST_KEPT, {8'b0, pixel_v} < {cfg.h, 16'b0} >> 8)
endmodule

@@ hdl/pfc_front.sv @@
// first cell: depth test, magnitudes and products
module pfc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  pfc_pkg::cfg_t                  cfg,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic [pfc_pkg::COORD_W-1:0]    pos_x,
  input  logic [pfc_pkg::COORD_W-1:0]    pos_y,
  input  logic [pfc_pkg::COORD_W-1:0]    pos_z,
  input  logic [pfc_pkg::IDX_W-1:0]      idx,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output pfc_pkg::front_t                dn_item
);
  import pfc_pkg::*;

  logic [COORD_W-1:0] ax, ay;
  logic               dfail;
  front_t             item_next;

  assign up_ready = !dn_valid || dn_ready;
  assign ax = pos_x[COORD_W-1] ? (~pos_x + 1'b1) : pos_x;
  assign ay = pos_y[COORD_W-1] ? (~pos_y + 1'b1) : pos_y;
  assign dfail = ($signed(pos_z) < $signed({1'b0, cfg.near})) ||
                 ($signed(pos_z) > $signed({1'b0, cfg.far}));

  always_comb begin
    item_next.idx        = idx;
    item_next.depth_fail = dfail;
    item_next.xneg       = pos_x[COORD_W-1];
    item_next.yneg       = pos_y[COORD_W-1];
    item_next.z          = pos_z[DEPTH_W-1:0];
    item_next.fx         = ax * cfg.focal;
    item_next.fy         = ay * cfg.focal;
    item_next.zw         = pos_z[DEPTH_W-1:0] * cfg.w;
    item_next.zh         = pos_z[DEPTH_W-1:0] * cfg.h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= item_next;
    end
  end
endmodule

@@ hdl/pfc_screen.sv @@
// second cell: field of view test and divider setup
module pfc_screen (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  pfc_pkg::front_t up_item,
  output logic            dn_valid,
  input  logic            dn_ready,
  output pfc_pkg::div_t   dn_item
);
  import pfc_pkg::*;

  logic [PROD_W:0] lhs_x, lhs_y, rhs_x, rhs_y;
  div_t            item_next;

  assign up_ready = !dn_valid || dn_ready;
  // |c| * 2f against z * size * 256
  assign lhs_x = {up_item.fx, 1'b0};
  assign lhs_y = {up_item.fy, 1'b0};
  assign rhs_x = {2'b0, up_item.zw, 8'b0};
  assign rhs_y = {2'b0, up_item.zh, 8'b0};

  always_comb begin
    item_next.idx  = up_item.idx;
    item_next.xneg = up_item.xneg;
    item_next.yneg = up_item.yneg;
    item_next.z    = up_item.z;
    item_next.ru   = up_item.fx;
    item_next.rv   = up_item.fy;
    item_next.qu   = '0;
    item_next.qv   = '0;
    if (up_item.depth_fail) begin
      item_next.status = ST_DEPTH;
    end else if (!(lhs_x < rhs_x) || !(lhs_y < rhs_y)) begin
      item_next.status = ST_FOV;
    end else begin
      item_next.status = ST_KEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= item_next;
    end
  end
endmodule

@@ hdl/pfc_div_cell.sv @@
// divider cell: one quotient bit for u and v
module pfc_div_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  pfc_pkg::div_t up_item,
  output logic          dn_valid,
  input  logic          dn_ready,
  output pfc_pkg::div_t dn_item
);
  import pfc_pkg::*;

  logic [PROD_W-1:0] dsh;
  logic              take_u, take_v;
  div_t              item_next;

  assign up_ready = !dn_valid || dn_ready;
  assign dsh    = {{(PROD_W-DEPTH_W){1'b0}}, up_item.z} << BIT;
  assign take_u = up_item.ru >= dsh;
  assign take_v = up_item.rv >= dsh;

  always_comb begin
    item_next = up_item;
    if (take_u) begin
      item_next.ru      = up_item.ru - dsh;
      item_next.qu[BIT] = 1'b1;
    end
    if (take_v) begin
      item_next.rv      = up_item.rv - dsh;
      item_next.qv[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= item_next;
    end
  end
endmodule

@@ hdl/pfc_back.sv @@
// last cell: sign, principal offset, image bounds, output register
module pfc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  pfc_pkg::cfg_t                 cfg,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  pfc_pkg::div_t                 up_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfc_pkg::IDX_W-1:0]     point_index_out,
  output logic [pfc_pkg::FOC_W-1:0]     pixel_u,
  output logic [pfc_pkg::FOC_W-1:0]     pixel_v,
  output logic [pfc_pkg::STATUS_W-1:0]  status
);
  import pfc_pkg::*;

  localparam int SW = QUO_W + 3;

  logic signed [SW-1:0] qu_s, qv_s, u, v;
  logic [SW-2:0]        lim_w, lim_h;
  logic                 off;
  logic [STATUS_W-1:0]  st_next;

  assign up_ready = !out_valid || out_ready;
  assign qu_s  = up_item.xneg ? -$signed({3'b0, up_item.qu}) : $signed({3'b0, up_item.qu});
  assign qv_s  = up_item.yneg ? -$signed({3'b0, up_item.qv}) : $signed({3'b0, up_item.qv});
  assign u     = qu_s + $signed({3'b0, cfg.px});
  assign v     = qv_s + $signed({3'b0, cfg.py});
  assign lim_w = {2'b0, cfg.w, 8'b0};
  assign lim_h = {2'b0, cfg.h, 8'b0};
  assign off   = u[SW-1] || (u[SW-2:0] >= lim_w) || v[SW-1] || (v[SW-2:0] >= lim_h);

  always_comb begin
    st_next = up_item.status;
    if (up_item.status == ST_KEPT && off) begin
      st_next = ST_IMAGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      point_index_out <= up_item.idx;
      status          <= st_next;
      pixel_u         <= (st_next == ST_KEPT) ? u[FOC_W-1:0] : '0;
      pixel_v         <= (st_next == ST_KEPT) ? v[FOC_W-1:0] : '0;
    end
  end
endmodule

@@ tb/pfc_checker.sv @@
// checker for the point frustum cull block: watches both channels and the register port
module pfc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [pfc_pkg::COORD_W-1:0]     pos_x,
  input  logic [pfc_pkg::COORD_W-1:0]     pos_y,
  input  logic [pfc_pkg::COORD_W-1:0]     pos_z,
  input  logic [pfc_pkg::IDX_W-1:0]       point_index,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [pfc_pkg::IDX_W-1:0]       point_index_out,
  input  logic [pfc_pkg::FOC_W-1:0]       pixel_u,
  input  logic [pfc_pkg::FOC_W-1:0]       pixel_v,
  input  logic [pfc_pkg::STATUS_W-1:0]    status,
  output int                              fail_count,
  output int                              pending
);
  import pfc_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [FOC_W-1:0]    u;
    logic [FOC_W-1:0]    v;
    logic [STATUS_W-1:0] st;
  } proj_t;

  cfg_t  regs;
  proj_t proj_q[$];

  assign pending = proj_q.size();

  function automatic longint unsigned mag(longint c);
    return c < 0 ? longint'(-c) : c;
  endfunction

  function automatic proj_t project_point(logic [31:0] xr, logic [31:0] yr,
                                          logic [31:0] zr, logic [IDX_W-1:0] idx);
    proj_t r;
    longint x, y, z, u, v;
    longint unsigned f, qu, qv;
    x = longint'(signed'(xr));
    y = longint'(signed'(yr));
    z = longint'(signed'(zr));
    f = regs.focal;
    r = '0;
    r.idx = idx;
    if (z < longint'(regs.near) || z > longint'(regs.far)) begin
      r.st = ST_DEPTH;
    end else if (!(mag(x) * 2 * f < longint'(z) * regs.w * 256) ||
                 !(mag(y) * 2 * f < longint'(z) * regs.h * 256)) begin
      r.st = ST_FOV;
    end else begin
      // quotient on magnitudes, sign applied after, so truncation is toward zero
      qu = f * mag(x) / longint'(z);
      qv = f * mag(y) / longint'(z);
      u = (x < 0 ? -longint'(qu) : longint'(qu)) + longint'(regs.px);
      v = (y < 0 ? -longint'(qv) : longint'(qv)) + longint'(regs.py);
      if (u < 0 || u >= longint'(regs.w) * 256 || v < 0 || v >= longint'(regs.h) * 256) begin
        r.st = ST_IMAGE;
      end else begin
        r.st = ST_KEPT;
        r.u  = u[FOC_W-1:0];
        r.v  = v[FOC_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    proj_t want;
    proj_t got;
    if (rst) begin
      regs <= '{focal: 256000, px: 245760, py: 138240, w: 1920, h: 1080,
                near: 65536, far: 26214400};
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{point_index_out, pixel_u, pixel_v, status};
        if (proj_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result item: idx %h u %h v %h st %0d",
                     got.idx, got.u, got.v, got.st);
          fail_count <= fail_count + 1;
        end else begin
          want = proj_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: exp idx %h u %h v %h st %0d, got idx %h u %h v %h st %0d",
                       want.idx, want.u, want.v, want.st, got.idx, got.u, got.v, got.st);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        proj_q.insert(proj_q.size(), project_point(pos_x, pos_y, pos_z, point_index));
      if (cfg_write) begin
        case (cfg_index)
          REG_FOCAL: regs.focal <= cfg_data[FOC_W-1:0];
          REG_PX:    regs.px    <= cfg_data[FOC_W-1:0];
          REG_PY:    regs.py    <= cfg_data[FOC_W-1:0];
          REG_W:     regs.w     <= cfg_data[SIZE_W-1:0];
          REG_H:     regs.h     <= cfg_data[SIZE_W-1:0];
          REG_NEAR:  regs.near  <= cfg_data[DEPTH_W-1:0];
          REG_FAR:   regs.far   <= cfg_data[DEPTH_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

@@ tb/tb_point_frustum_cull_project.sv @@
// top of the point frustum cull testbench: stimulus, register phases and verdict
module tb_point_frustum_cull_project;
  import pfc_pkg::*;

  // one past the register list, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int DRAIN_CYCLES = 40;   // chain is 27 cells deep

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [COORD_W-1:0]    pos_x, pos_y, pos_z;
  logic [IDX_W-1:0]      point_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [IDX_W-1:0]      point_index_out;
  logic [FOC_W-1:0]      pixel_u, pixel_v;
  logic [STATUS_W-1:0]   status;
  int                    fail_count;
  int                    pending;

  // idling is switched off for the closing phase
  bit                    idling;
  int                    stall_left;
  // shadow of the live settings, used only to aim random points
  longint unsigned       cur[7];

  point_frustum_cull_project dut (.*);

  pfc_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver side: ready drops at random while idling is set
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(7, 0) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(8, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // write enable stays up across back to back writes, the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    if (idx != REG_UNUSED) cur[idx] = val;
    @(posedge clk);
  endtask

  // one point item; valid holds until the block takes it
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [IDX_W-1:0] idx);
    if (idling && $urandom_range(3, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pos_x       <= x;
    pos_y       <= y;
    pos_z       <= z;
    point_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    // let the checker log the last accepted item first
    @(posedge clk);
    while (pending != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random coordinate up to a quarter past the field of view edge for depth z
  function automatic logic [31:0] aim_axis(longint unsigned z, longint unsigned size);
    longint unsigned lim;
    logic [31:0] m;
    lim = (cur[0] == 0) ? 64'h7fffffff : z * size * 128 / cur[0];
    lim = lim + lim / 4 + 1;
    if (lim > 64'h7fffffff) lim = 64'h7fffffff;
    m = $urandom_range(lim[31:0], 0);
    return $urandom_range(1, 0) ? -m : m;
  endfunction

  function automatic logic [31:0] pick_depth();
    longint unsigned near, far;
    near = cur[5];
    far  = cur[6];
    case ($urandom_range(9, 0))
      0: return near[31:0];
      1: return far[31:0];
      2: return near[31:0] - 1;
      3: return far[31:0] + 1;
      4: return $urandom();
      default: begin
        if (near > far) return $urandom_range(near[31:0], far[31:0]);
        // favor shallow points so the projection is not always near center
        if ($urandom_range(1, 0) && far - near > 64'd2000000)
          return $urandom_range(near[31:0] + 2000000, near[31:0]);
        return $urandom_range(far[31:0], near[31:0]);
      end
    endcase
  endfunction

  task automatic set_phase(int p);
    longint unsigned v[7];
    case (p)
      1: v = '{256000, 245760, 138240, 1920, 1080, 65536, 26214400};
      2: v = '{256, 0, 0, 1, 1, 0, 64'h7fffffff};
      3: v = '{24'hffffff, 24'hffffff, 24'hffffff, 16'hffff, 16'hffff, 65536, 64'h7fffffff};
      4: v = '{0, 1000, 2000, 640, 480, 1, 655360};                 // zero focal length
      5: v = '{300000, 80000, 60000, 640, 480, 2000000, 1000000};    // near above far
      6: v = '{300000, 80000, 60000, 0, 100, 1000, 9000000};        // zero image width
      7: v = '{$urandom_range(24'hffffff, 256), $urandom_range(24'hffffff, 0),
               $urandom_range(24'hffffff, 0), $urandom_range(16'hffff, 1),
               $urandom_range(16'hffff, 1), $urandom_range(32'h7fffffff, 0),
               $urandom_range(32'h7fffffff, 0)};
      default: v = '{512000, 327680, 245760, 2560, 1920, 32768, 64'h7ffffffe};
    endcase
    for (int i = 0; i < 7; i++) write_reg(i[CFG_IDX_W-1:0], v[i]);
    if (p == 1) write_reg(REG_UNUSED, 31'h5a5a5a5);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [31:0] z;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    pos_x       = '0;
    pos_y       = '0;
    pos_z       = '0;
    point_index = '0;
    idling      = 1'b1;
    cur = '{256000, 245760, 138240, 1920, 1080, 65536, 26214400};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed points under the reset settings
    send_point(0, 0, 65536, 0);                                 // dead center at near
    send_point(0, 0, 26214400, 24'hffffff);                     // center at far
    send_point(0, 0, 65535, 1);                                 // just short of near
    send_point(0, 0, 26214401, 2);                              // just past far
    send_point(0, 0, 0, 3);                                     // zero depth
    send_point(0, 0, 32'h80000000, 4);                          // most negative depth
    send_point(0, 0, 32'h7fffffff, 5);                          // deepest
    send_point(32'h7fffffff, 32'h7fffffff, 26214400, 6);        // far outside view
    send_point(32'h80000000, 32'h80000000, 26214400, 7);
    send_point(32'd65535, 32'd0, 32'd65536, 8);                 // just outside the right edge of the view
    send_point(-32'd65535, -32'd36863, 32'd65536, 9);           // just outside the top left corner of the view
    send_point(32'd16000, -32'd9000, 32'd65536, 10);
    send_point(-32'd1, 32'd1, 32'd131072, 11);                  // truncation toward zero
    send_point(32'd245760, 32'd0, 32'd262144, 12);              // near the right edge, still on the image
    send_point(32'hffffffff, 32'hffffffff, 32'hffffffff, 24'h800000);
    wait_idle();

    for (int p = 1; p <= NUM_PHASES; p++) begin
      if (p == NUM_PHASES) idling = 1'b0;
      set_phase(p);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(6, 0) == 0) begin
          // noise: any bit pattern
          send_point($urandom(), $urandom(), $urandom(), $urandom());
        end else begin
          z = pick_depth();
          send_point(aim_axis(z, cur[3]), aim_axis(z, cur[4]), z, $urandom());
        end
      end
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hdl
hdl/pfc_pkg.sv
hdl/pfc_front.sv
hdl/pfc_screen.sv
hdl/pfc_div_cell.sv
hdl/pfc_back.sv
hdl/point_frustum_cull_project.sv
tb/pfc_checker.sv
tb/tb_point_frustum_cull_project.sv
